// ===== sv/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

  localparam int unsigned HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned ADDR_W       = $clog2(HEAP_BYTES);
  localparam int unsigned SIZE_W       = 17;
  localparam int unsigned HDR_W        = SIZE_W + ADDR_W + 2;

  localparam logic [SIZE_W-1:0] HDR_SZ    = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NOSPACE  = 3'd1,
    STAT_NULL     = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_NOTALLOC = 3'd4
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [16:0] req_size;
    logic [16:0] free_offset;
    logic        free_is_null;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] alloc_offset;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] nxt;
    logic              has_nxt;
    logic              alloc;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE,
    ST_A_RD, ST_A_CHK, ST_A_WN, ST_A_WC, ST_A_WP,
    ST_F_RH, ST_F_CH, ST_F_RD, ST_F_WK, ST_F_GA, ST_F_WH, ST_F_WP
  } state_t;

endpackage
`default_nettype wire

// ===== sv/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a 64 KiB heap whose block headers live in a
// header memory with one write port and one read port. After reset the block
// sweeps the whole header memory once and accepts no word meanwhile. An
// allocate walks the free list from its head, one block header at a time; a
// free walks the free blocks below the freed one before it links it in. One
// word is handled at a time, and a new word is taken once the previous result
// has been delivered.
`default_nettype none
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic head_ok_r, head_ok_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, nx_r, nx_nxt;
  logic cur_ok_r, cur_ok_nxt, prev_ok_r, prev_ok_nxt, nx_ok_r, nx_ok_nxt;
  logic split_r, split_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  hdr_t cur_hdr_r, cur_hdr_nxt, prev_hdr_r, prev_hdr_nxt;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_r, out_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  hdr_t              wdata, rd;
  logic [HDR_W-1:0]  rdata;

  ffha_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_BYTES)) u_hdr_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign rd = hdr_t'(rdata);

  logic              accept, fit, split, oob, after_lt, adj_ha, adj_ph;
  logic [SIZE_W-1:0] left;
  logic [SIZE_W:0]   nx18, ha18, ph18;
  logic [SIZE_W-1:0] h_off;
  logic              rng_bad;
  status_t           pre_stat;

  assign accept   = in_valid && in_ready;
  assign fit      = rd.size > req_r;
  assign left     = rd.size - req_r;
  assign split    = left > HDR_SZ;
  assign nx18     = {2'b00, cur_r} + {1'b0, HDR_SZ} + {1'b0, req_r};
  assign oob      = nx18[SIZE_W:ADDR_W] != '0;
  assign after_lt = nx_r < cur_r;
  assign ha18     = {2'b00, cur_r} + {1'b0, HDR_SZ} + {1'b0, cur_hdr_r.size};
  assign adj_ha   = ha18 == {2'b00, nx_r};
  assign ph18     = {2'b00, prev_r} + {1'b0, HDR_SZ} + {1'b0, prev_hdr_r.size};
  assign adj_ph   = ph18 == {2'b00, cur_r};
  assign h_off    = in_data.free_offset - HDR_SZ;
  assign rng_bad  = (in_data.free_offset < HDR_SZ) || (h_off[SIZE_W-1:ADDR_W] != '0);

  always_comb begin
    if (in_data.free_is_null) begin
      pre_stat = STAT_NULL;
    end else if (rng_bad) begin
      pre_stat = STAT_RANGE;
    end else begin
      pre_stat = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      head_ok_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      head_ok_r   <= head_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cur_ok_r   <= cur_ok_nxt;
    prev_r     <= prev_nxt;
    prev_ok_r  <= prev_ok_nxt;
    nx_r       <= nx_nxt;
    nx_ok_r    <= nx_ok_nxt;
    split_r    <= split_nxt;
    req_r      <= req_nxt;
    cur_hdr_r  <= cur_hdr_nxt;
    prev_hdr_r <= prev_hdr_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_ALLOC) begin
            state_nxt = ST_A_RD;
          end else if (pre_stat == STAT_OK) begin
            state_nxt = ST_F_RH;
          end
        end
      end
      ST_A_RD:  state_nxt = cur_ok_r ? ST_A_CHK : ST_IDLE;
      ST_A_CHK: begin
        if (!fit) begin
          state_nxt = ST_A_RD;
        end else if (split) begin
          state_nxt = oob ? ST_IDLE : ST_A_WN;
        end else begin
          state_nxt = ST_A_WC;
        end
      end
      ST_A_WN: state_nxt = ST_A_WC;
      ST_A_WC: state_nxt = ST_A_WP;
      ST_A_WP: state_nxt = ST_IDLE;
      ST_F_RH: state_nxt = ST_F_CH;
      ST_F_CH: state_nxt = rd.alloc ? ST_F_RD : ST_IDLE;
      ST_F_RD: begin
        if (nx_ok_r && after_lt) begin
          state_nxt = ST_F_WK;
        end else if (nx_ok_r) begin
          state_nxt = ST_F_GA;
        end else begin
          state_nxt = ST_F_WH;
        end
      end
      ST_F_WK: state_nxt = ST_F_RD;
      ST_F_GA: state_nxt = ST_F_WH;
      ST_F_WH: state_nxt = ST_F_WP;
      ST_F_WP: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    head_ok_nxt   = head_ok_r;
    cur_nxt       = cur_r;
    cur_ok_nxt    = cur_ok_r;
    prev_nxt      = prev_r;
    prev_ok_nxt   = prev_ok_r;
    nx_nxt        = nx_r;
    nx_ok_nxt     = nx_ok_r;
    split_nxt     = split_r;
    req_nxt       = req_r;
    cur_hdr_nxt   = cur_hdr_r;
    prev_hdr_nxt  = prev_hdr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = cur_r;
    wdata         = cur_hdr_r;
    raddr         = cur_r;
    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        if (clr_r == '0) begin
          wdata.size = INIT_SIZE;
        end
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt     = in_data.req_size;
          cur_nxt     = head_r;
          cur_ok_nxt  = head_ok_r;
          prev_ok_nxt = 1'b0;
          if (in_data.req_type == REQ_FREE) begin
            cur_nxt = h_off[ADDR_W-1:0];
            if (pre_stat != STAT_OK) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: pre_stat, alloc_offset: '0};
            end
          end
        end
      end
      ST_A_RD: begin
        raddr = cur_r;
        if (!cur_ok_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: STAT_NOSPACE, alloc_offset: '0};
        end
      end
      ST_A_CHK: begin
        cur_hdr_nxt = rd;
        split_nxt   = split;
        if (!fit) begin
          prev_nxt     = cur_r;
          prev_ok_nxt  = 1'b1;
          prev_hdr_nxt = rd;
          cur_nxt      = rd.nxt;
          cur_ok_nxt   = rd.has_nxt;
        end else if (split) begin
          nx_nxt    = nx18[ADDR_W-1:0];
          nx_ok_nxt = 1'b1;
          if (oob) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: STAT_NOSPACE, alloc_offset: '0};
          end
        end else begin
          nx_nxt    = rd.nxt;
          nx_ok_nxt = rd.has_nxt;
        end
      end
      ST_A_WN: begin
        we            = 1'b1;
        waddr         = nx_r;
        wdata         = cur_hdr_r;
        wdata.size    = cur_hdr_r.size - req_r - HDR_SZ;
        wdata.alloc   = 1'b0;
      end
      ST_A_WC: begin
        we          = 1'b1;
        waddr       = cur_r;
        wdata       = cur_hdr_r;
        wdata.alloc = 1'b1;
        if (split_r) begin
          wdata.size = req_r;
        end
      end
      ST_A_WP: begin
        if (prev_ok_r) begin
          we            = 1'b1;
          waddr         = prev_r;
          wdata         = prev_hdr_r;
          wdata.nxt     = nx_r;
          wdata.has_nxt = nx_ok_r;
        end else begin
          head_nxt    = nx_r;
          head_ok_nxt = nx_ok_r;
        end
        out_valid_nxt = 1'b1;
        out_nxt = '{status: STAT_OK,
                    alloc_offset: {1'b0, cur_r} + HDR_SZ};
      end
      ST_F_RH: raddr = cur_r;
      ST_F_CH: begin
        cur_hdr_nxt       = rd;
        cur_hdr_nxt.alloc = 1'b0;
        nx_nxt            = head_r;
        nx_ok_nxt         = head_ok_r;
        if (!rd.alloc) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: STAT_NOTALLOC, alloc_offset: '0};
        end
      end
      ST_F_RD: begin
        raddr               = nx_r;
        cur_hdr_nxt.nxt     = nx_r;
        cur_hdr_nxt.has_nxt = nx_ok_r;
      end
      ST_F_WK: begin
        prev_nxt     = nx_r;
        prev_ok_nxt  = 1'b1;
        prev_hdr_nxt = rd;
        nx_nxt       = rd.nxt;
        nx_ok_nxt    = rd.has_nxt;
      end
      ST_F_GA: begin
        if (adj_ha) begin
          cur_hdr_nxt.size    = cur_hdr_r.size + rd.size + HDR_SZ;
          cur_hdr_nxt.nxt     = rd.nxt;
          cur_hdr_nxt.has_nxt = rd.has_nxt;
        end
      end
      ST_F_WH: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = cur_hdr_r;
      end
      ST_F_WP: begin
        if (prev_ok_r) begin
          we            = 1'b1;
          waddr         = prev_r;
          wdata         = prev_hdr_r;
          wdata.nxt     = cur_r;
          wdata.has_nxt = 1'b1;
          if (adj_ph) begin
            wdata.size    = prev_hdr_r.size + cur_hdr_r.size + HDR_SZ;
            wdata.nxt     = cur_hdr_r.nxt;
            wdata.has_nxt = cur_hdr_r.has_nxt;
          end
        end else begin
          head_nxt    = cur_r;
          head_ok_nxt = 1'b1;
        end
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: STAT_OK, alloc_offset: '0};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("ready outside idle");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.alloc_offset == '0)
    else $error("offset on error");
  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_OK && out_data.alloc_offset != '0
    |-> out_data.alloc_offset >= HDR_SZ)
    else $error("offset below header");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready right after accept");

endmodule
`default_nettype wire
